// ===== hdl/tgs_pkg.sv =====
// Shared types and constants for the terrain gradient stencil.
package tgs_pkg;

  localparam int ELEV_W      = 16;
  localparam int GRAD_W      = 24;
  localparam int ROW_W       = 16;
  localparam int COL_W       = 11;
  localparam int DIFF_W      = 19;
  localparam int WIDTH_W     = 12;
  localparam int CS_W        = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAC_SHIFT  = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS   = GRAD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL   = 2'd2;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     last;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic             restart;
    logic [ROW_W-1:0] last_row;
    logic [CS_W-1:0]  divisor;
  } cfg_t;

  typedef enum logic [1:0] {F_IDLE, F_READ, F_EMIT} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_HOLD} back_state_t;

endpackage

// ===== hdl/tgs_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
interface tgs_in_if import tgs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [ELEV_W-1:0] elevation;
  modport source (output valid, output elevation, input ready);
  modport sink (input valid, input elevation, output ready);
endinterface

interface tgs_out_if import tgs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] east_west_gradient;
  logic signed [GRAD_W-1:0] north_south_gradient;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_column;
  logic                     last_of_run;
  modport source (output valid, output east_west_gradient, output north_south_gradient,
                  output out_row, output out_column, output last_of_run, input ready);
  modport sink (input valid, input east_west_gradient, input north_south_gradient,
                input out_row, input out_column, input last_of_run, output ready);
endinterface

interface tgs_cfg_if import tgs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tgs_front.sv =====
// Front end: row stores, window, and classification of each item into gradient jobs.
module tgs_front import tgs_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  tgs_in_if.sink        in_s,
  input  cfg_t          cfg,
  input  logic [AW-1:0] last_col,
  input  q_stat_t       q_stat,
  output q_push_t       q_push
);

  front_state_t state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt, cur_row_r;
  logic [AW-1:0]    col_r, col_nxt, cur_col_r;
  logic signed [ELEV_W-1:0] elev_r;
  logic signed [ELEV_W-1:0] win_r [6];
  logic [1:0] idx_r, idx_nxt;
  logic [2*ELEV_W-1:0] store [MAX_WIDTH];
  logic [2*ELEV_W-1:0] rd_q;
  logic [ROW_W-1:0] row_c;
  logic [AW-1:0]    col_c;
  logic accept, wr_en, finish, advance;
  logic [3:0] app;
  logic [1:0] rc, cc, m, n, x, y;
  logic [ROW_W-1:0] jr;
  logic [AW-1:0]    jc;
  logic first_r, last_r, first_c, last_c, is_last;
  logic signed [DIFF_W-1:0] ew_pos, ew_neg, ns_pos, ns_neg;

  function automatic logic signed [DIFF_W-1:0] cellv(
    input logic [1:0] r, input logic [1:0] c,
    input logic signed [ELEV_W-1:0] w0 [6],
    input logic [2*ELEV_W-1:0] rd, input logic signed [ELEV_W-1:0] e);
    logic signed [ELEV_W-1:0] v;
    v = '0;
    case (c)
      2'd0: v = (r == 2'd0) ? w0[0] : (r == 2'd1) ? w0[1] : w0[2];
      2'd1: v = (r == 2'd0) ? w0[3] : (r == 2'd1) ? w0[4] : w0[5];
      default: begin
        v = (r == 2'd0) ? $signed(rd[2*ELEV_W-1:ELEV_W]) :
            (r == 2'd1) ? $signed(rd[ELEV_W-1:0]) : e;
      end
    endcase
    return DIFF_W'(v);
  endfunction

  assign accept = in_s.valid && in_s.ready;
  assign row_c  = (row_r > cfg.last_row) ? cfg.last_row : row_r;
  assign col_c  = (col_r > last_col) ? last_col : col_r;

  // Row stores: upper in the high half, middle in the low half.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= store[col_c];
    end
    if (wr_en) begin
      store[cur_col_r] <= {rd_q[ELEV_W-1:0], elev_r};
    end
  end

  // Job classification and difference computation.
  always_comb begin
    app[0] = (cur_row_r != '0) && (cur_col_r != '0);
    app[1] = (cur_row_r != '0) && (cur_col_r == last_col);
    app[2] = (cur_row_r == cfg.last_row) && (cur_col_r != '0);
    app[3] = (cur_row_r == cfg.last_row) && (cur_col_r == last_col);
    rc = idx_r[1] ? 2'd2 : 2'd1;
    cc = idx_r[0] ? 2'd2 : 2'd1;
    jr = idx_r[1] ? cur_row_r : cur_row_r - 1'b1;
    jc = idx_r[0] ? cur_col_r : cur_col_r - 1'b1;
    first_r = (jr == '0);
    last_r  = (jr == cfg.last_row);
    first_c = (jc == '0);
    last_c  = (jc == last_col);
    m = first_r ? rc : rc - 2'd1;
    n = (last_r || rc == 2'd2) ? rc : rc + 2'd1;
    x = first_c ? cc : cc - 2'd1;
    y = (last_c || cc == 2'd2) ? cc : cc + 2'd1;
    ew_pos = DIFF_W'(2 * cellv(rc, y, win_r, rd_q, elev_r) + cellv(m, y, win_r, rd_q, elev_r)
           + cellv(n, y, win_r, rd_q, elev_r));
    ew_neg = DIFF_W'(2 * cellv(rc, x, win_r, rd_q, elev_r) + cellv(m, x, win_r, rd_q, elev_r)
           + cellv(n, x, win_r, rd_q, elev_r));
    ns_pos = DIFF_W'(2 * cellv(n, cc, win_r, rd_q, elev_r) + cellv(n, x, win_r, rd_q, elev_r)
           + cellv(n, y, win_r, rd_q, elev_r));
    ns_neg = DIFF_W'(2 * cellv(m, cc, win_r, rd_q, elev_r) + cellv(m, x, win_r, rd_q, elev_r)
           + cellv(m, y, win_r, rd_q, elev_r));
    case (idx_r)
      2'd0:    is_last = (app[3:1] == 3'b000);
      2'd1:    is_last = (app[3:2] == 2'b00);
      2'd2:    is_last = !app[3];
      default: is_last = 1'b1;
    endcase
  end

  assign advance = !app[idx_r] || !q_stat.full;
  assign finish  = (state_r == F_EMIT) && advance && (idx_r == 2'd3);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_READ;
      F_READ:  state_nxt = F_EMIT;
      F_EMIT:  if (finish) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    in_s.ready      = (state_r == F_IDLE);
    wr_en           = (state_r == F_READ);
    q_push.push     = (state_r == F_EMIT) && app[idx_r] && !q_stat.full;
    q_push.job.dx   = ew_pos - ew_neg;
    q_push.job.dy   = ns_pos - ns_neg;
    q_push.job.row  = jr;
    q_push.job.col  = COL_W'(jc);
    q_push.job.last = is_last;
    idx_nxt = idx_r;
    if (state_r == F_READ) begin
      idx_nxt = 2'd0;
    end else if (state_r == F_EMIT && advance) begin
      idx_nxt = idx_r + 2'd1;
    end
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg.restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (finish) begin
      if (cur_col_r == last_col) begin
        col_nxt = '0;
        row_nxt = (cur_row_r == cfg.last_row) ? '0 : cur_row_r + 1'b1;
      end else begin
        col_nxt = cur_col_r + 1'b1;
        row_nxt = cur_row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elev_r    <= in_s.elevation;
      cur_row_r <= row_c;
      cur_col_r <= col_c;
    end
    if (finish) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= $signed(rd_q[2*ELEV_W-1:ELEV_W]);
      win_r[4] <= $signed(rd_q[ELEV_W-1:0]);
      win_r[5] <= elev_r;
    end
  end

endmodule

// ===== hdl/tgs_queue.sv =====
// Small job queue between the front end and the divider back end.
module tgs_queue import tgs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  job_t entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_pop;

  assign do_pop       = pop && (cnt_r != '0);
  assign head         = entry_r[rd_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.count = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push.push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push.push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push.push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entry_r[wr_r] <= q_push.job;
    end
  end

endmodule

// ===== hdl/tgs_back.sv =====
// Back end: two bit-serial dividers scale both differences, then a result register.
module tgs_back import tgs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  job_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  tgs_out_if.source out_s
);

  back_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [GRAD_W-1:0] nx_r, ny_r, nx_nxt, ny_nxt;
  logic [CS_W-1:0]   rx_r, ry_r, rx_nxt, ry_nxt, div_r;
  logic [CS_W:0]     remx, remy;
  logic              gex, gey, sx_r, sy_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic              last_r;
  logic signed [GRAD_W-1:0] ew_r, ns_r;
  logic [DIFF_W-1:0] ax, ay;
  logic done;

  assign ax = head.dx[DIFF_W-1] ? DIFF_W'(-head.dx) : DIFF_W'(head.dx);
  assign ay = head.dy[DIFF_W-1] ? DIFF_W'(-head.dy) : DIFF_W'(head.dy);

  // One restoring step per cycle for each difference.
  always_comb begin
    remx   = {rx_r, nx_r[GRAD_W-1]};
    remy   = {ry_r, ny_r[GRAD_W-1]};
    gex    = (remx >= {1'b0, div_r});
    gey    = (remy >= {1'b0, div_r});
    rx_nxt = gex ? CS_W'(remx - {1'b0, div_r}) : CS_W'(remx);
    ry_nxt = gey ? CS_W'(remy - {1'b0, div_r}) : CS_W'(remy);
    nx_nxt = {nx_r[GRAD_W-2:0], gex};
    ny_nxt = {ny_r[GRAD_W-2:0], gey};
  end

  assign done = (state_r == B_DIV) && (step_r == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_stat.empty) state_nxt = B_DIV;
      B_DIV:   if (done) state_nxt = B_HOLD;
      B_HOLD:  if (out_s.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop                        = (state_r == B_IDLE) && !q_stat.empty;
    out_s.valid                = (state_r == B_HOLD);
    out_s.east_west_gradient   = ew_r;
    out_s.north_south_gradient = ns_r;
    out_s.out_row              = row_r;
    out_s.out_column           = col_r;
    out_s.last_of_run          = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      nx_r   <= GRAD_W'({ax, FRAC_SHIFT'(0)});
      ny_r   <= GRAD_W'({ay, FRAC_SHIFT'(0)});
      rx_r   <= '0;
      ry_r   <= '0;
      sx_r   <= head.dx[DIFF_W-1];
      sy_r   <= head.dy[DIFF_W-1];
      div_r  <= (cfg.divisor == '0) ? CS_W'(1) : cfg.divisor;
      row_r  <= head.row;
      col_r  <= head.col;
      last_r <= head.last;
      step_r <= '0;
    end else if (state_r == B_DIV) begin
      nx_r   <= nx_nxt;
      ny_r   <= ny_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      step_r <= step_r + 1'b1;
    end
    if (done) begin
      ew_r <= sx_r ? -$signed(nx_nxt) : $signed(nx_nxt);
      ns_r <= sy_r ? -$signed(ny_nxt) : $signed(ny_nxt);
    end
  end

endmodule

// ===== hdl/terrain_gradient_stencil.sv =====
// Top level of the Horn 3x3 terrain gradient stencil.
// The block takes a raster-order stream of signed 16-bit elevations, one item per cell,
// and returns for each cell its east-west and north-south Horn gradients, each as
// trunc(weighted difference * 32 / cell spacing), a signed value with 5 fraction bits.
// Edge cells use the clamped neighbors of the Horn scheme. Results trail the input by
// one row and one column, so one item releases from zero to four results, and the last
// of them carries last_of_run. The front end takes no new item until it is through with
// the last: it accepts the item while reading the row stores, writes them back, then
// steps through the four possible results and queues those that apply; a full job
// queue stretches those steps. Each result then passes through the back end: it takes
// the job, the two bit-serial dividers retire the 24 quotient bits one at a time for
// both differences, and the result waits on the result channel. The sustained rate is
// set by those dividers, as the back end takes no new job until its result has left. A
// four-entry job queue lets the front keep accepting while the back end works or
// waits on the result channel. The configuration port is always ready, one
// write per cycle, and should be written only while no item is in flight; every write
// to a valid register restarts the frame at row 0, column 0. Out-of-range settings are
// clamped: widths to 2..MAX_WIDTH, heights to at least 2, and a zero cell size acts
// as 1. Row store contents are not cleared by reset, and none of them reaches a result
// before being written within the current frame.
module terrain_gradient_stencil import tgs_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  tgs_cfg_if.sink   cfg_s,
  tgs_in_if.sink    in_s,
  tgs_out_if.source out_s
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [CS_W-1:0]    cell_r;
  logic [AW-1:0]      last_col;
  logic               cfg_acc;
  cfg_t               cfg;
  q_push_t            q_push;
  q_stat_t            q_stat;
  job_t               head;
  logic               pop;

  assign cfg_s.ready = 1'b1;
  assign cfg_acc     = cfg_s.valid && cfg_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(2048);
      height_r <= ROW_W'(2048);
      cell_r   <= CS_W'(1);
    end else if (cfg_acc) begin
      case (cfg_s.index)
        REG_WIDTH:  width_r  <= cfg_s.data[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_s.data[ROW_W-1:0];
        REG_CELL:   cell_r   <= cfg_s.data[CS_W-1:0];
        default:    ;
      endcase
    end
  end

  // Effective last column and last row after clamping.
  always_comb begin
    if (width_r < WIDTH_W'(2)) begin
      last_col = AW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      last_col = AW'(MAX_WIDTH - 1);
    end else begin
      last_col = AW'(width_r - 1'b1);
    end
    cfg.last_row = (height_r < ROW_W'(2)) ? ROW_W'(1) : height_r - 1'b1;
    cfg.divisor  = cell_r;
    cfg.restart  = cfg_acc && (cfg_s.index == REG_WIDTH || cfg_s.index == REG_HEIGHT ||
                               cfg_s.index == REG_CELL);
  end

  tgs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_s),
    .cfg      (cfg),
    .last_col (last_col),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  tgs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  tgs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_s  (out_s)
  );

  // The front end never pushes a job into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // An accepted item keeps the input closed in the following cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> !in_s.ready)
    else $error("input reopened right after an accepted item");

  // The back end only takes a job when one is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_stat.count != '0))
    else $error("job taken from an empty queue");

endmodule
